FILE: src/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher block.
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int BOX_SIZE          = 256;
    localparam int BOX_AW            = 8;
    localparam int KEY_CNT_W         = 9;
    localparam int MAX_KEY_BYTES_DEF = 256;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_D_J,
        ST_D_X,
        ST_D_W,
        ST_K_RD,
        ST_K_ACC,
        ST_K_WR1,
        ST_K_WR2
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } result_t;

endpackage

FILE: src/rc4_stream_cipher.sv
// RC4 stream cipher: stream ports, output register and the cipher core.
//
// Send key bytes with tuser low, one request each; the request with tlast set
// starts the key schedule. The key schedule first reloads the identity
// permutation, one entry per cycle, then runs 256 rounds through the states
// K_RD, K_ACC, K_WR1 and K_WR2, while the input stays not ready. The same
// identity load runs once after reset before the first request is taken.
// Data bytes (tuser high) come back as data XOR keystream with tlast echoed;
// key bytes give no result. A data byte passes through the states D_J, D_X
// and D_W before a new request is taken: each keystream step needs two
// dependent reads, two writes and one output read on the single read and
// single write port of the permutation memory. A finished result waits in the
// output register, so the next request is taken while it is still held. Key
// bytes beyond MAX_KEY_BYTES are dropped; a dropped byte with tlast set still
// starts the schedule over the stored bytes.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] value
    input  logic       s_axis_tuser,   // [0] kind
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    rc4_pkg::result_t           result;
    logic                       out_free;
    logic                       out_valid_reg, out_valid_next;
    logic [rc4_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;

    rc4_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .in_value (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .out_free (out_free),
        .result   (result)
    );

    // The register can take a new result when empty or being drained now.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = result.data_byte;
            out_last_next  = result.last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: src/rc4_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rc4_core.sv
// Sequencer and datapath around the permutation and key memories.
module rc4_core #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_kind,
    input  logic [rc4_pkg::BYTE_W-1:0] in_value,
    input  logic                       in_last,
    input  logic                       out_free,
    output rc4_pkg::result_t           result
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int BW     = rc4_pkg::BYTE_W;
    localparam int AW     = rc4_pkg::BOX_AW;
    localparam int CW     = rc4_pkg::KEY_CNT_W;

    rc4_pkg::state_t state_reg, state_next;

    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [BW-1:0]     acc_reg, acc_next;
    logic [KEY_AW-1:0] kpos_reg, kpos_next;
    logic [CW-1:0]     key_count_reg, key_count_next;
    logic              sched_reg, sched_next;

    logic [BW-1:0]     value_reg, value_next;
    logic              last_reg, last_next;
    logic [BW-1:0]     si_reg, si_next;
    logic [BW-1:0]     sj_reg, sj_next;
    logic              fwd_i_reg, fwd_i_next;
    logic              fwd_j_reg, fwd_j_next;

    logic              p_we, p_re;
    logic [AW-1:0]     p_waddr, p_raddr;
    logic [BW-1:0]     p_wdata, p_rdata;
    logic              k_we, k_re;
    logic [KEY_AW-1:0] k_waddr, k_raddr;
    logic [BW-1:0]     k_rdata;

    logic              accept;
    logic [AW-1:0]     idx;
    logic [BW-1:0]     ks;
    logic [CW-1:0]     key_len;
    logic [CW-1:0]     kpos_inc;

    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (rc4_pkg::BOX_SIZE)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (p_waddr),
        .wr_data (p_wdata),
        .rd_en   (p_re),
        .rd_addr (p_raddr),
        .rd_data (p_rdata)
    );

    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (k_we),
        .wr_addr (k_waddr),
        .wr_data (in_value),
        .rd_en   (k_re),
        .rd_addr (k_raddr),
        .rd_data (k_rdata)
    );

    assign in_ready = (state_reg == rc4_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign idx      = si_reg + p_rdata;
    assign key_len  = (key_count_reg == '0) ? CW'(1) : key_count_reg;
    assign kpos_inc = CW'(kpos_reg) + CW'(1);

    // The swap writes S[j] last, so a match on j takes priority over i.
    assign ks = fwd_j_reg ? si_reg : (fwd_i_reg ? sj_reg : p_rdata);

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        kpos_next      = kpos_reg;
        key_count_next = key_count_reg;
        sched_next     = sched_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        fwd_i_next     = fwd_i_reg;
        fwd_j_next     = fwd_j_reg;

        p_we    = 1'b0;
        p_waddr = cnt_reg;
        p_wdata = cnt_reg;
        p_re    = 1'b0;
        p_raddr = i_reg + AW'(1);
        k_we    = 1'b0;
        k_waddr = key_count_reg[KEY_AW-1:0];
        k_re    = 1'b0;
        k_raddr = kpos_reg;

        result.valid     = 1'b0;
        result.data_byte = value_reg ^ ks;
        result.last      = last_reg;

        unique case (state_reg)
            rc4_pkg::ST_FILL:
            begin
                p_we     = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == '1)
                begin
                    state_next = sched_reg ? rc4_pkg::ST_K_RD : rc4_pkg::ST_IDLE;
                end
            end

            rc4_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == rc4_pkg::KIND_DATA)
                    begin
                        p_re       = 1'b1;
                        i_next     = i_reg + AW'(1);
                        value_next = in_value;
                        last_next  = in_last;
                        state_next = rc4_pkg::ST_D_J;
                    end
                    else
                    begin
                        if (key_count_reg < CW'(MAX_KEY_BYTES))
                        begin
                            k_we           = 1'b1;
                            key_count_next = key_count_reg + CW'(1);
                        end
                        if (in_last)
                        begin
                            sched_next = 1'b1;
                            cnt_next   = '0;
                            acc_next   = '0;
                            kpos_next  = '0;
                            state_next = rc4_pkg::ST_FILL;
                        end
                    end
                end
            end

            rc4_pkg::ST_D_J:
            begin
                si_next    = p_rdata;
                j_next     = j_reg + p_rdata;
                p_re       = 1'b1;
                p_raddr    = j_reg + p_rdata;
                state_next = rc4_pkg::ST_D_X;
            end

            rc4_pkg::ST_D_X:
            begin
                p_we       = 1'b1;
                p_waddr    = i_reg;
                p_wdata    = p_rdata;
                sj_next    = p_rdata;
                p_re       = 1'b1;
                p_raddr    = idx;
                fwd_i_next = (idx == i_reg);
                fwd_j_next = (idx == j_reg);
                state_next = rc4_pkg::ST_D_W;
            end

            rc4_pkg::ST_D_W:
            begin
                // Rewriting S[j] while the output waits is harmless.
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                if (out_free)
                begin
                    result.valid = 1'b1;
                    state_next   = rc4_pkg::ST_IDLE;
                end
            end

            rc4_pkg::ST_K_RD:
            begin
                p_re       = 1'b1;
                p_raddr    = cnt_reg;
                k_re       = 1'b1;
                state_next = rc4_pkg::ST_K_ACC;
            end

            rc4_pkg::ST_K_ACC:
            begin
                acc_next   = acc_reg + p_rdata + k_rdata;
                si_next    = p_rdata;
                p_re       = 1'b1;
                p_raddr    = acc_reg + p_rdata + k_rdata;
                state_next = rc4_pkg::ST_K_WR1;
            end

            rc4_pkg::ST_K_WR1:
            begin
                p_we       = 1'b1;
                p_waddr    = cnt_reg;
                p_wdata    = p_rdata;
                state_next = rc4_pkg::ST_K_WR2;
            end

            rc4_pkg::ST_K_WR2:
            begin
                p_we     = 1'b1;
                p_waddr  = acc_reg;
                p_wdata  = si_reg;
                cnt_next = cnt_reg + AW'(1);
                if (kpos_inc >= key_len)
                begin
                    kpos_next = '0;
                end
                else
                begin
                    kpos_next = kpos_inc[KEY_AW-1:0];
                end
                if (cnt_reg == '1)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                    sched_next     = 1'b0;
                    state_next     = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_K_RD;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_FILL;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            kpos_reg      <= '0;
            key_count_reg <= '0;
            sched_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            kpos_reg      <= kpos_next;
            key_count_reg <= key_count_next;
            sched_reg     <= sched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
        si_reg    <= si_next;
        sj_reg    <= sj_next;
        fwd_i_reg <= fwd_i_next;
        fwd_j_reg <= fwd_j_next;
    end

endmodule

FILE: src/rc4_chk.sv
// Port-level checker for the RC4 stream cipher, bound to the top level.
module rc4_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A key byte never brings a result with it.
    a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && s_axis_tuser == rc4_pkg::KIND_KEY && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after a key byte");

    // The last key byte starts the schedule, which blocks the input.
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && s_axis_tuser == rc4_pkg::KIND_KEY && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready during key schedule");

    // A data byte into an empty output yields its result with its last flag.
    a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && s_axis_tuser == rc4_pkg::KIND_DATA && !m_axis_tvalid |->
            ##4 m_axis_tvalid && m_axis_tlast == $past(s_axis_tlast, 4))
        else $error("data result missing or last flag wrong");

endmodule

bind rc4_stream_cipher rc4_chk u_rc4_chk (.*);

FILE: test/rc4_stream_cipher_test.sv
// Self-checking testbench for the RC4 stream cipher block with random stream traffic.
module rc4_stream_cipher_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W   = rc4_pkg::BYTE_W;
    localparam int BOX_SIZE = rc4_pkg::BOX_SIZE;

    // Number of random requests after the directed tests.
    localparam int RANDOM_ITEMS = 560;
    // Cycles allowed after the last result, in case a late stray result shows up.
    localparam int TAIL_CYCLES  = 32;
    // Hard cycle limit, well above the slowest correct run: that run is bounded by
    // the key schedules, the random idle gaps on both sides and the keystream
    // steps of the data bytes.
    localparam int CYCLE_LIMIT  = 1_500_000;

    // One cipher result as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_flag;
    } cipher_out_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] value
    logic       s_axis_tuser;   // [0] kind
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;

    // Predicted cipher state, kept in step with every accepted request.
    logic [BYTE_W-1:0] perm_sbox [BOX_SIZE];
    logic [BYTE_W-1:0] key_bytes [BOX_SIZE];
    logic [BYTE_W-1:0] idx_i;
    logic [BYTE_W-1:0] idx_j;
    int                key_len;

    // Cipher bytes that the block still owes, oldest first.
    cipher_out_t expected_cipher_out[$];

    int  error_count = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    // When set, the matching side runs without any idle cycles.
    bit  tx_no_idle  = 1'b0;
    bit  rx_no_stall = 1'b0;

    rc4_stream_cipher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Cipher prediction
    // ------------------------------------------------------------------

    // Reset state of the cipher: identity permutation, both indices zero, empty key.
    function automatic void reset_prediction();
        for (int k = 0; k < BOX_SIZE; k++)
            perm_sbox[k] = BYTE_W'(k);
        idx_i   = '0;
        idx_j   = '0;
        key_len = 0;
    endfunction

    // Key schedule over the key bytes stored since the previous schedule. The
    // key is repeated cyclically over the 256 rounds.
    function automatic void run_key_schedule();
        int                n;
        int                kpos;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] tmp;
        n    = (key_len == 0) ? 1 : key_len;
        kpos = 0;
        acc  = '0;
        for (int k = 0; k < BOX_SIZE; k++)
            perm_sbox[k] = BYTE_W'(k);
        for (int r = 0; r < BOX_SIZE; r++)
        begin
            acc            = acc + perm_sbox[r] + key_bytes[kpos];
            tmp            = perm_sbox[r];
            perm_sbox[r]   = perm_sbox[acc];
            perm_sbox[acc] = tmp;
            kpos           = (kpos + 1 >= n) ? 0 : kpos + 1;
        end
        idx_i   = '0;
        idx_j   = '0;
        key_len = 0;
    endfunction

    // One step of the keystream generator; returns the keystream byte.
    function automatic logic [BYTE_W-1:0] next_keystream_byte();
        logic [BYTE_W-1:0] tmp;
        logic [BYTE_W-1:0] pick;
        idx_i            = idx_i + 1'b1;
        idx_j            = idx_j + perm_sbox[idx_i];
        tmp              = perm_sbox[idx_i];
        perm_sbox[idx_i] = perm_sbox[idx_j];
        perm_sbox[idx_j] = tmp;
        pick             = perm_sbox[idx_i] + perm_sbox[idx_j];
        return perm_sbox[pick];
    endfunction

    // Applies one accepted request to the predicted state. Key bytes are stored
    // until the store is full; surplus ones are dropped, but their last flag
    // still starts the schedule. Data bytes owe one cipher byte each.
    function automatic void predict_cipher(input logic kind, input logic [7:0] value,
                                           input logic last);
        cipher_out_t res;
        if (kind == rc4_pkg::KIND_KEY)
        begin
            if (key_len < rc4_pkg::MAX_KEY_BYTES_DEF)
            begin
                key_bytes[key_len] = value;
                key_len++;
            end
            if (last)
                run_key_schedule();
        end
        else
        begin
            res.data_byte = value ^ next_keystream_byte();
            res.last_flag = last;
            expected_cipher_out.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one request after a random gap and waits for the handshake. The
    // valid stays high on return, so a following request with no gap goes out
    // back to back; anything else that follows must lower it at once.
    task automatic send_request(input logic kind, input logic [7:0] value,
                                input logic last);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_cipher(kind, value, last);
        items_sent++;
    endtask

    // Stops sending and waits until every owed cipher byte has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_cipher_out.size() != 0);
    endtask

    // A key of len random bytes; the final byte closes the key when close is set.
    task automatic send_key(input int len, input bit close);
        for (int n = 0; n < len; n++)
            send_request(rc4_pkg::KIND_KEY, 8'($urandom_range(0, 255)),
                         close && (n == len - 1));
    endtask

    // A run of random data bytes; last is set now and then and on the final byte.
    task automatic send_data_run(input int len);
        for (int n = 0; n < len; n++)
            send_request(rc4_pkg::KIND_DATA, 8'($urandom_range(0, 255)),
                         (n == len - 1) || ($urandom_range(0, 7) == 0));
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Takes results with random stalls and checks each field against the
    // oldest owed cipher byte.
    initial
    begin : result_checker
        cipher_out_t want;
        int          stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            if (expected_cipher_out.size() == 0)
            begin
                report_mismatch("result with no data byte outstanding", m_axis_tdata,
                                8'hxx);
            end
            else
            begin
                want = expected_cipher_out.pop_front();
                if (m_axis_tdata !== want.data_byte)
                    report_mismatch("cipher byte", m_axis_tdata, want.data_byte);
                if (m_axis_tlast !== want.last_flag)
                    report_mismatch("last flag", 8'(m_axis_tlast), 8'(want.last_flag));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Data before any key runs the generator from the reset permutation.
    task automatic test_keystream_from_reset();
        send_request(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'hFF, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'hA5, 1'b1);
        send_request(rc4_pkg::KIND_DATA, 8'h5A, 1'b0);
    endtask

    // One-byte keys at both value extremes; the key byte itself starts the schedule.
    task automatic test_short_keys();
        send_request(rc4_pkg::KIND_KEY, 8'h00, 1'b1);
        send_request(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'hFF, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'h3C, 1'b1);
        send_request(rc4_pkg::KIND_KEY, 8'hFF, 1'b1);
        send_request(rc4_pkg::KIND_DATA, 8'h81, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'h7E, 1'b1);
    endtask

    // Key bytes that arrive during a data run are only stored: the keystream
    // runs on until the closing key byte. The sender then waits for every
    // owed result before going on, so the block sees a fully idle output.
    task automatic test_key_during_data();
        send_request(rc4_pkg::KIND_KEY, 8'h01, 1'b0);
        send_request(rc4_pkg::KIND_KEY, 8'h02, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'h10, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'hEF, 1'b1);
        send_request(rc4_pkg::KIND_KEY, 8'h80, 1'b1);
        wait_for_drain();
        send_request(rc4_pkg::KIND_DATA, 8'h55, 1'b0);
        send_request(rc4_pkg::KIND_DATA, 8'hAA, 1'b1);
    endtask

    // A key that fills the store exactly, and one with surplus bytes where a
    // dropped byte carries the last flag and still starts the schedule.
    task automatic test_full_and_surplus_keys();
        send_key(rc4_pkg::MAX_KEY_BYTES_DEF, 1'b1);
        send_data_run(4);
        send_key(rc4_pkg::MAX_KEY_BYTES_DEF + 3, 1'b1);
        send_data_run(4);
    endtask

    // Mostly well-formed key-then-data sequences with random content, mixed
    // with bare data runs, unfinished keys broken up by data, and now and
    // then a full or overfull key. The idle behavior of both sides changes
    // from one sequence to the next.
    task automatic test_random_traffic();
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            tx_no_idle  = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            pick        = $urandom_range(0, 39);
            if (pick == 0)
            begin
                send_key(rc4_pkg::MAX_KEY_BYTES_DEF + $urandom_range(0, 4), 1'b1);
                send_data_run($urandom_range(1, 16));
            end
            else if (pick <= 4)
            begin
                send_key($urandom_range(1, 5), 1'b0);
                send_data_run($urandom_range(1, 10));
            end
            else if (pick <= 8)
                send_data_run($urandom_range(1, 20));
            else
            begin
                send_key($urandom_range(1, 16), 1'b1);
                send_data_run($urandom_range(8, 60));
            end
            if ($urandom_range(0, 19) == 0)
                wait_for_drain();
        end
        tx_no_idle  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // Main sequence: reset once, run the tests in turn, drain and judge.
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= rc4_pkg::KIND_KEY;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        reset_prediction();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_keystream_from_reset();
        test_short_keys();
        test_key_during_data();
        test_full_and_surplus_keys();
        test_random_traffic();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
